[src/ktaf_pkg.sv]
package ktaf_pkg;

  // Fixed field widths of the sample word and the register file
  localparam int GYRO_W   = 32;
  localparam int ACCEL_W  = 32;
  localparam int MS_W     = 10;
  localparam int IN_TDATA_W = 80;
  localparam int CFG_W    = 31;
  localparam int APB_AW   = 4;

  // dt scaling: ms to seconds, rounded to nearest
  localparam int DTS_SCALE = 1000;
  localparam int DTS_HALF  = 500;

  // divide by 1000 one 16-bit digit at a time; ceil(2^36/1000) as reciprocal
  // is exact for partial dividends below 1000 * 2^16
  localparam int DTS_DIGIT_W  = 16;
  localparam int DTS_REM_W    = 10;
  localparam int DTS_RECIP_SH = 36;
  localparam int DTS_RECIP_W  = 27;
  localparam logic [DTS_RECIP_W-1:0] DTS_RECIP = 27'd68719477;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_QA = 2'd0;
  localparam logic [1:0] REG_QB = 2'd1;
  localparam logic [1:0] REG_R  = 2'd2;

  localparam logic [CFG_W-1:0] QA_RESET = 31'd16777;
  localparam logic [CFG_W-1:0] QB_RESET = 31'd50332;
  localparam logic [CFG_W-1:0] R_RESET  = 31'd8388608;

  // filter steps, in execution order
  typedef enum logic [3:0] {
    T_DTS_RATE, T_DTS_AA, T_DTS_BB, T_DTS_QB,
    T_GAIN0, T_GAIN1,
    T_MQ_ANGLE, T_MQ_BIAS, T_MQ_AA, T_MQ_AB, T_MQ_BA, T_MQ_BB
  } task_t;

  typedef enum logic [1:0] {K_DTS, K_GAIN, K_MQ} kind_t;

  function automatic kind_t kind_of(task_t t);
    kind_t k;
    case (t) inside
      T_DTS_RATE, T_DTS_AA, T_DTS_BB, T_DTS_QB: k = K_DTS;
      T_GAIN0, T_GAIN1:                         k = K_GAIN;
      default:                                  k = K_MQ;
    endcase
    return k;
  endfunction

  typedef struct packed {
    logic  in_load;
    logic  load;
    logic  mul;
    logic  div_start;
    logic  wb;
    logic  out_load;
    task_t tsk;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic den_pos;
  } stat_t;

endpackage

[src/ktaf_div.sv]
module ktaf_div #(
  parameter int NW  = 56,
  parameter int DVW = 33
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [NW-1:0]  num,
  input  logic [DVW-1:0] den,
  output logic           done,
  output logic [NW-1:0]  quot
);

  localparam int CW = $clog2(NW + 1);

  logic           busy;
  logic [CW-1:0]  cnt;
  logic [DVW-1:0] rem;
  logic [DVW-1:0] dsr;
  logic [DVW:0]   trial;
  logic [DVW:0]   diff;
  logic           qbit;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem, quot[NW-1]};
    diff  = trial - {1'b0, dsr};
    qbit  = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
      dsr  <= den;
    end else if (busy) begin
      quot <= {quot[NW-2:0], qbit};
      rem  <= qbit ? diff[DVW-1:0] : trial[DVW-1:0];
    end
  end

endmodule

[src/ktaf_dpath.sv]
module ktaf_dpath import ktaf_pkg::*; #(
  parameter int DATA_WIDTH    = 32,
  parameter int COV_FRAC_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  output stat_t                        stat,
  input  logic signed [GYRO_W-1:0]     in_gyro_rate,
  input  logic signed [ACCEL_W-1:0]    in_accel_angle,
  input  logic [MS_W-1:0]              in_interval_ms,
  input  logic [CFG_W-1:0]             qa,
  input  logic [CFG_W-1:0]             qb,
  input  logic [CFG_W-1:0]             r,
  output logic signed [DATA_WIDTH-1:0] angle_estimate,
  output logic signed [DATA_WIDTH-1:0] rate_estimate,
  output logic signed [DATA_WIDTH-1:0] bias_estimate
);

  localparam int W   = DATA_WIDTH;
  localparam int F   = COV_FRAC_BITS;
  localparam int XW  = (W > GYRO_W) ? W : GYRO_W;
  localparam int VW  = XW + 2;
  localparam int SW  = VW + 2;
  localparam int PW  = W + VW;
  localparam int NW  = W + F;
  localparam int DVW = ((W > CFG_W) ? W : CFG_W) + 1;
  localparam int RW  = PW + 1 - F;

  // dt scaling divide: dividend width, digits, partial dividend width
  localparam int DXW = VW + MS_W + 1;
  localparam int DND = (DXW + DTS_DIGIT_W - 1) / DTS_DIGIT_W;
  localparam int DAW = DND * DTS_DIGIT_W;
  localparam int DCW = $clog2(DND + 1);
  localparam int YW  = DTS_REM_W + DTS_DIGIT_W;
  localparam int YPW = YW + DTS_RECIP_W;

  localparam logic signed [SW-1:0] SMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic [W-1:0]         LIM  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W:0]           MCLAMP = {1'b1, {W{1'b0}}};
  localparam logic signed [W-1:0]  ONE  = W'(1) << F;

  function automatic logic signed [W-1:0] sat_w(logic signed [SW-1:0] x);
    logic signed [W-1:0] y;
    if (x > SMAX)      y = SMAX[W-1:0];
    else if (x < SMIN) y = SMIN[W-1:0];
    else               y = x[W-1:0];
    return y;
  endfunction

  // sample and filter state
  logic signed [GYRO_W-1:0]  gyro;
  logic signed [ACCEL_W-1:0] accel;
  logic [MS_W-1:0]           ms;
  logic signed [W-1:0] angle, bias, aa, ab, ba, bb;
  logic signed [W-1:0] angle_p, p_aa, p_ab, p_ba, p_bb, k0, k1;

  // shared multiplier operands
  logic [W-1:0]  op_a, op_a_next;
  logic [VW-1:0] op_b, op_b_next;
  logic          neg, neg_next;
  logic [PW-1:0] prod;

  kind_t               kind;
  logic signed [VW-1:0] v_sel, err;
  logic signed [W-1:0]  k_sel;
  logic signed [SW-1:0] den;
  logic                 den_pos;

  logic [NW-1:0]  div_num, div_quot;
  logic [DVW-1:0] div_den;
  logic           div_done;

  // divide by 1000 for the dt scaling
  logic                   dts_start, dts_busy, dts_done;
  logic [DCW-1:0]         dts_cnt;
  logic [DXW-1:0]         dts_num;
  logic [DAW-1:0]         dts_acc;
  logic [DTS_REM_W-1:0]   dts_rem;
  logic [YW-1:0]          dts_y, dts_qm, dts_rnew;
  logic [YPW-1:0]         dts_prod;
  logic [DTS_DIGIT_W-1:0] dts_qd;

  logic [VW-1:0]        dq;
  logic signed [SW-1:0] dz, d_s;
  logic [W-1:0]         gq;
  logic signed [W-1:0]  k_new;
  logic [PW:0]          rnd;
  logic [RW-1:0]        sh;
  logic [W:0]           mm;
  logic signed [SW-1:0] mz, m_s;

  assign kind = kind_of(cmd.tsk);
  assign err  = VW'(accel) - VW'(angle_p);
  assign den  = SW'($signed({1'b0, r})) + SW'(p_aa);

  assign den_pos = !den[SW-1] && (den != '0);
  assign stat    = '{div_done: div_done || dts_done, den_pos: den_pos};

  // operand select
  always_comb begin
    case (cmd.tsk) inside
      T_DTS_RATE:                 v_sel = VW'(gyro) - VW'(bias);
      T_DTS_AA:                   v_sel = VW'($signed({1'b0, qa})) - VW'(ab) - VW'(ba);
      T_DTS_BB:                   v_sel = VW'(bb);
      T_DTS_QB:                   v_sel = VW'($signed({1'b0, qb}));
      T_GAIN0, T_MQ_AA, T_MQ_BA:  v_sel = VW'(p_aa);
      T_GAIN1, T_MQ_AB, T_MQ_BB:  v_sel = VW'(p_ab);
      default:                    v_sel = err;
    endcase
    case (cmd.tsk) inside
      T_MQ_ANGLE, T_MQ_AA, T_MQ_AB: k_sel = k0;
      default:                      k_sel = k1;
    endcase
    op_b_next = v_sel[VW-1] ? VW'(-v_sel) : VW'(v_sel);
    if (kind == K_MQ) begin
      op_a_next = k_sel[W-1] ? W'(-k_sel) : W'(k_sel);
      neg_next  = k_sel[W-1] ^ v_sel[VW-1];
    end else begin
      op_a_next = W'(ms);
      neg_next  = v_sel[VW-1];
    end
  end

  // gain quotient on the radix-2 divider
  assign div_num = NW'(op_b) << F;
  assign div_den = den[DVW-1:0];

  ktaf_div #(.NW(NW), .DVW(DVW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start && (kind == K_GAIN)),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // dt scaling: (|v|*ms + 500) / 1000, one 16-bit digit per cycle, MSB first
  assign dts_start = cmd.div_start && (kind == K_DTS);
  assign dts_num   = DXW'(prod) + DXW'(DTS_HALF);

  always_comb begin
    dts_y    = {dts_rem, dts_acc[DAW-1 -: DTS_DIGIT_W]};
    dts_prod = YPW'(dts_y) * YPW'(DTS_RECIP);
    dts_qd   = dts_prod[DTS_RECIP_SH +: DTS_DIGIT_W];
    dts_qm   = YW'(dts_qd) * YW'(DTS_SCALE);
    dts_rnew = dts_y - dts_qm;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dts_busy <= 1'b0;
      dts_done <= 1'b0;
      dts_cnt  <= '0;
    end else begin
      dts_done <= 1'b0;
      if (dts_start) begin
        dts_busy <= 1'b1;
        dts_cnt  <= '0;
      end else if (dts_busy) begin
        dts_cnt <= dts_cnt + 1'b1;
        if (dts_cnt == DCW'(DND - 1)) begin
          dts_busy <= 1'b0;
          dts_done <= 1'b1;
        end
      end
    end
  end

  // quotient digits shift in at the bottom as dividend digits leave the top
  always_ff @(posedge clk) begin
    if (dts_start) begin
      dts_acc <= DAW'(dts_num);
      dts_rem <= '0;
    end else if (dts_busy) begin
      dts_acc <= {dts_acc[DAW-DTS_DIGIT_W-1:0], dts_qd};
      dts_rem <= dts_rnew[DTS_REM_W-1:0];
    end
  end

  // result shaping
  always_comb begin
    dq  = dts_acc[VW-1:0];
    dz  = {{(SW-VW){1'b0}}, dq};
    d_s = neg ? -dz : dz;

    gq    = (div_quot > NW'(LIM)) ? LIM : div_quot[W-1:0];
    k_new = !den_pos ? '0 : (neg ? -$signed(gq) : $signed(gq));

    rnd = (PW+1)'(prod) + ((PW+1)'(1) << (F - 1));
    sh  = rnd[PW:F];
    mm  = (sh > RW'(MCLAMP)) ? MCLAMP : sh[W:0];
    mz  = {{(SW-W-1){1'b0}}, mm};
    m_s = neg ? -mz : mz;
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      gyro  <= in_gyro_rate;
      accel <= in_accel_angle;
      ms    <= in_interval_ms;
    end
    if (cmd.load) begin
      op_a <= op_a_next;
      op_b <= op_b_next;
      neg  <= neg_next;
    end
    if (cmd.mul) begin
      prod <= op_a * op_b;
    end
    if (cmd.wb) begin
      case (cmd.tsk)
        T_DTS_RATE: angle_p <= sat_w(SW'(angle) + d_s);
        T_DTS_AA:   p_aa    <= sat_w(SW'(aa) + d_s);
        T_DTS_BB: begin
          p_ab <= sat_w(SW'(ab) - d_s);
          p_ba <= sat_w(SW'(ba) - d_s);
        end
        T_DTS_QB:   p_bb    <= sat_w(SW'(bb) + d_s);
        T_GAIN0:    k0      <= k_new;
        T_GAIN1:    k1      <= k_new;
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      angle_estimate <= angle;
      bias_estimate  <= bias;
      rate_estimate  <= sat_w(SW'(gyro) - SW'(bias));
    end
  end

  // filter state: written back by the correction steps
  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
      bias  <= '0;
      aa    <= ONE;
      ab    <= '0;
      ba    <= '0;
      bb    <= ONE;
    end else if (cmd.wb) begin
      case (cmd.tsk)
        T_MQ_ANGLE: angle <= sat_w(SW'(angle_p) + m_s);
        T_MQ_BIAS:  bias  <= sat_w(SW'(bias) + m_s);
        T_MQ_AA:    aa    <= sat_w(SW'(p_aa) - m_s);
        T_MQ_AB:    ab    <= sat_w(SW'(p_ab) - m_s);
        T_MQ_BA:    ba    <= sat_w(SW'(p_ba) - m_s);
        T_MQ_BB:    bb    <= sat_w(SW'(p_bb) - m_s);
        default: ;
      endcase
    end
  end

endmodule

[src/ktaf_ctrl.sv]
module ktaf_ctrl import ktaf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  output logic  m_tvalid,
  input  logic  m_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MUL, S_DIV_GO, S_DIV_WAIT, S_WB, S_DONE
  } state_t;

  state_t state;
  task_t  tsk;
  kind_t  kind;
  logic   out_ok;

  assign kind   = kind_of(tsk);
  assign out_ok = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.tsk       = tsk;
    cmd.in_load   = (state == S_IDLE) && s_tvalid;
    cmd.load      = (state == S_LOAD);
    cmd.mul       = (state == S_MUL);
    cmd.div_start = (state == S_DIV_GO);
    cmd.wb        = (state == S_WB);
    cmd.out_load  = (state == S_DONE) && out_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      tsk      <= T_DTS_RATE;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          tsk <= T_DTS_RATE;
          if (s_tvalid) state <= S_LOAD;
        end
        S_LOAD: begin
          if (kind == K_GAIN) state <= stat.den_pos ? S_DIV_GO : S_WB;
          else                state <= S_MUL;
        end
        S_MUL:      state <= (kind == K_DTS) ? S_DIV_GO : S_WB;
        S_DIV_GO:   state <= S_DIV_WAIT;
        S_DIV_WAIT: if (stat.div_done) state <= S_WB;
        S_WB: begin
          if (tsk == T_MQ_BB) begin
            state <= S_DONE;
          end else begin
            tsk   <= task_t'(tsk + 1'b1);
            state <= S_LOAD;
          end
        end
        S_DONE:     if (out_ok) state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> state == S_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_out_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("result loaded but not presented");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && m_tvalid && !m_tready |=> state == S_DONE)
    else $error("new result would overwrite a pending word");

endmodule

[src/kalman_tilt_angle_filter.sv]
// Two-state Kalman tilt filter (angle and gyro bias, 2x2 covariance).
// Input stream: one word per IMU sample on s_tvalid/s_tready/s_tdata.
//   s_tdata[31:0] gyro_rate (Q16.16), [63:32] accel_angle (Q16.16),
//   [73:64] interval_ms, upper bits zero.
// Output stream: one word per sample on m_tvalid/m_tready/m_tdata,
//   angle_estimate, rate_estimate, bias_estimate from the low bits up.
// Config: APB, noise registers at 0x0 (angle), 0x4 (bias), 0x8 (measure),
//   31-bit unsigned Q7.24; user must write only while no sample is in flight.
// Structure: one sample at a time. The work is a sequence of steps on one
//   multiplier, a radix-2 divider for the two gains (NW = DATA_WIDTH +
//   COV_FRAC_BITS quotient bits) and a 16-bit-digit reciprocal divide by
//   1000 for the four dt scalings, followed by six correction steps.
// Reset clears angle and bias, sets the covariance to identity and restores
//   the default noise registers. A stalled receiver holds the output word;
//   the next sample is taken meanwhile and finishes into a wait until the
//   pending word is taken.
module kalman_tilt_angle_filter import ktaf_pkg::*; #(
  parameter int DATA_WIDTH    = 32,
  parameter int COV_FRAC_BITS = 24,
  localparam int OUT_TDATA_W  = ((3 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst,
  // gyro_rate, accel_angle, interval_ms
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [IN_TDATA_W-1:0]   s_tdata,
  // angle_estimate, rate_estimate, bias_estimate
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OUT_TDATA_W-1:0]  m_tdata,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [CFG_W-1:0] qa, qb, r;
  logic [1:0]       reg_idx;
  logic             cfg_wr;
  cmd_t             cmd;
  stat_t            stat;

  logic signed [DATA_WIDTH-1:0] angle_estimate, rate_estimate, bias_estimate;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // noise registers; out-of-range index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      qa <= QA_RESET;
      qb <= QB_RESET;
      r  <= R_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_QA:  qa <= pwdata[CFG_W-1:0];
        REG_QB:  qb <= pwdata[CFG_W-1:0];
        REG_R:   r  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_QA:  prdata = 32'(qa);
      REG_QB:  prdata = 32'(qb);
      REG_R:   prdata = 32'(r);
      default: prdata = '0;
    endcase
  end

  ktaf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ktaf_dpath #(
    .DATA_WIDTH    (DATA_WIDTH),
    .COV_FRAC_BITS (COV_FRAC_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_gyro_rate   (s_tdata[GYRO_W-1:0]),
    .in_accel_angle (s_tdata[GYRO_W+ACCEL_W-1:GYRO_W]),
    .in_interval_ms (s_tdata[GYRO_W+ACCEL_W+MS_W-1:GYRO_W+ACCEL_W]),
    .qa             (qa),
    .qb             (qb),
    .r              (r),
    .angle_estimate (angle_estimate),
    .rate_estimate  (rate_estimate),
    .bias_estimate  (bias_estimate)
  );

  assign m_tdata = OUT_TDATA_W'({bias_estimate, rate_estimate, angle_estimate});

endmodule
